// File: sv/aho_pkg.sv
// Shared types, constants and helper functions for the additive harmonic oscillator.
`default_nettype none
package aho_pkg;

  localparam int LANE_COUNT = 4;
  localparam int ACC_W      = 40;
  localparam int TOT_W      = 24;
  localparam int CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FM_DEPTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMITS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CV_MASK  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_A = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_B = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_C = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_D = 8'd7;

  localparam logic [31:0] Q30_ONE = 32'd1073741824;
  localparam logic [31:0] SIN_A1  = 32'd1686629713;
  localparam logic [31:0] SIN_A3  = 32'd693598668;
  localparam logic [31:0] SIN_A5  = 32'd85569306;
  localparam logic [31:0] SIN_A7  = 32'd5026995;
  localparam logic [31:0] SIN_A9  = 32'd172272;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [TOT_W-1:0]        total;
  } aho_lane_res_t;

  // Q30 value of 2^(2^b / 4096) for fraction bit b.
  function automatic logic [30:0] exp2_bit(input logic [3:0] b);
    logic [30:0] v;
    case (b)
      4'd0:    v = 31'd1073923544;
      4'd1:    v = 31'd1074105294;
      4'd2:    v = 31'd1074468888;
      4'd3:    v = 31'd1075196443;
      4'd4:    v = 31'd1076653033;
      4'd5:    v = 31'd1079572136;
      4'd6:    v = 31'd1085434106;
      4'd7:    v = 31'd1097253708;
      4'd8:    v = 31'd1121280436;
      4'd9:    v = 31'd1170923762;
      4'd10:   v = 31'd1276901417;
      4'd11:   v = 31'd1518500250;
      default: v = 31'd1073741824;
    endcase
    return v;
  endfunction

  // Division by 32767 = 2^15 - 1 through folding of the high part.
  function automatic logic [15:0] div_by_32767(input logic [31:0] y);
    logic [16:0] q0;
    logic [17:0] r;
    logic [16:0] q1;
    logic [15:0] r1;
    q0 = y[31:15];
    r  = {3'b0, y[14:0]} + {1'b0, q0};
    q1 = q0 + {14'b0, r[17:15]};
    r1 = {1'b0, r[14:0]} + {13'b0, r[17:15]};
    if (r1 >= 16'd32767) begin
      q1 = q1 + 17'd1;
    end
    return q1[15:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/additive_harmonic_oscillator.sv
// Additive harmonic oscillator: up to sixteen sine harmonics summed per audio tick.
//
// Input channel (in_valid/in_ready) carries one audio tick: pitch_cv, fm_cv and
// four words of packed harmonic CV lanes. Output channel (out_valid/out_ready)
// carries one audio_out sample per tick. Configuration registers are written
// through cfg_write/cfg_index/cfg_data; the user must write them at an edge
// while the block is idle, which the block itself does not enforce. One tick
// is processed at a time. From transfer to out_valid a tick passes through
// the increment unit (with its 2^x mantissa loop), a state that starts the
// lanes, the four harmonic lanes (one shared multiplier per lane, eight steps
// per harmonic, SLOTS slots per lane, SLOTS being ceil(HARMONIC_COUNT / 4)
// rounded up to a power of two and at least two), the bit-serial normalizing
// divider and the load of the output register.
// The next tick is taken once the previous sample sits in the output register,
// so a stalled receiver holds that sample and blocks only after the following
// tick is complete. Reset clears the phase accumulator and restores register
// defaults; no clearing pass is needed.
`default_nettype none
module additive_harmonic_oscillator #(
  parameter int HARMONIC_COUNT = 16,
  parameter int SINE_ADDR_BITS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [15:0]                pitch_cv,
  input  wire logic signed [15:0]                fm_cv,
  input  wire logic [63:0]                       harm_cv_a,
  input  wire logic [63:0]                       harm_cv_b,
  input  wire logic [63:0]                       harm_cv_c,
  input  wire logic [63:0]                       harm_cv_d,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [15:0]                     audio_out,
  input  wire logic                              cfg_write,
  input  wire logic [aho_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [63:0]                       cfg_data
);
  import aho_pkg::*;

  localparam int SLOTS_RAW = (HARMONIC_COUNT + LANE_COUNT - 1) / LANE_COUNT;
  localparam int JW        = (SLOTS_RAW > 1) ? $clog2(SLOTS_RAW) : 1;
  localparam int SLOTS     = 1 << JW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INC   = 3'd1;
  localparam logic [2:0] ST_LGO   = 3'd2;
  localparam logic [2:0] ST_LANES = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]  state;
  logic [31:0] base_increment;
  logic [16:0] fm_depth;
  logic [63:0] increment_limits;
  logic [15:0] cv_connected_mask;
  logic [63:0] harm_levels_a;
  logic [63:0] harm_levels_b;
  logic [63:0] harm_levels_c;
  logic [63:0] harm_levels_d;
  logic [31:0] phase_acc;

  logic signed [15:0] pitch_r;
  logic signed [15:0] fm_r;
  logic [255:0]       cv_r;

  logic        accept;
  logic [31:0] inc;
  logic        inc_done;
  logic        lane_start;
  logic        lane_done [LANE_COUNT];
  logic        lanes_done;
  aho_lane_res_t lane_res [LANE_COUNT];
  logic signed [15:0] sample;
  logic        div_done;
  logic [255:0] levels_all;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign lane_start = (state == ST_LGO);
  assign levels_all = {harm_levels_d, harm_levels_c, harm_levels_b, harm_levels_a};

  // All lanes run in lockstep; the merge waits for every one of them.
  always_comb begin
    lanes_done = 1'b1;
    for (int l = 0; l < LANE_COUNT; l++) begin
      lanes_done = lanes_done & lane_done[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_increment    <= 32'd23443000;
      fm_depth          <= '0;
      increment_limits  <= 64'd7686143361182343924;
      cv_connected_mask <= '0;
      harm_levels_a     <= 64'd65535;
      harm_levels_b     <= '0;
      harm_levels_c     <= '0;
      harm_levels_d     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BASE_INC: base_increment    <= cfg_data[31:0];
        CFG_FM_DEPTH: fm_depth          <= cfg_data[16:0];
        CFG_LIMITS:   increment_limits  <= cfg_data;
        CFG_CV_MASK:  cv_connected_mask <= cfg_data[15:0];
        CFG_LEVELS_A: harm_levels_a     <= cfg_data;
        CFG_LEVELS_B: harm_levels_b     <= cfg_data;
        CFG_LEVELS_C: harm_levels_c     <= cfg_data;
        CFG_LEVELS_D: harm_levels_d     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pitch_r <= pitch_cv;
      fm_r    <= fm_cv;
      cv_r    <= {harm_cv_d, harm_cv_c, harm_cv_b, harm_cv_a};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT) begin
        if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_INC;
          end
        end
        ST_INC: begin
          if (inc_done) begin
            phase_acc <= phase_acc + inc;
            state     <= ST_LGO;
          end
        end
        ST_LGO: state <= ST_LANES;
        ST_LANES: begin
          if (lanes_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            audio_out <= sample;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  aho_increment u_inc (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .pitch    (pitch_r),
    .fm       (fm_r),
    .base_inc (base_increment),
    .fm_depth (fm_depth),
    .limits   (increment_limits),
    .inc      (inc),
    .done     (inc_done)
  );

  for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
    logic [15:0] level  [SLOTS];
    logic [15:0] cv     [SLOTS];
    logic        conn   [SLOTS];
    logic        hvalid [SLOTS];
    logic [4:0]  hnum   [SLOTS];

    for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      localparam int K = s * LANE_COUNT + l;
      if (K < HARMONIC_COUNT && K < 16) begin : g_used
        assign level[s]  = levels_all[16*K +: 16];
        assign cv[s]     = cv_r[16*K +: 16];
        assign conn[s]   = cv_connected_mask[K];
        assign hvalid[s] = 1'b1;
        assign hnum[s]   = 5'(K + 1);
      end else begin : g_unused
        assign level[s]  = '0;
        assign cv[s]     = '0;
        assign conn[s]   = 1'b0;
        assign hvalid[s] = 1'b0;
        assign hnum[s]   = '0;
      end
    end

    aho_lane #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .SLOTS          (SLOTS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (lane_start),
      .phase  (phase_acc),
      .level  (level),
      .cv     (cv),
      .conn   (conn),
      .hvalid (hvalid),
      .hnum   (hnum),
      .res    (lane_res[l]),
      .done   (lane_done[l])
    );
  end

  aho_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (lanes_done),
    .lane_res (lane_res),
    .sample   (sample),
    .done     (div_done)
  );
endmodule
`default_nettype wire

// File: sv/aho_increment.sv
// Phase increment unit: exponent, iterative 2^x mantissa, scaling and clamping.
`default_nettype none
module aho_increment (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] pitch,
  input  wire logic signed [15:0] fm,
  input  wire logic [31:0]        base_inc,
  input  wire logic [16:0]        fm_depth,
  input  wire logic [63:0]        limits,
  output logic [31:0]             inc,
  output logic                    done
);
  import aho_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FM    = 3'd1;
  localparam logic [2:0] S_MANT  = 3'd2;
  localparam logic [2:0] S_PROD  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;

  logic [2:0]         state;
  logic signed [18:0] e;
  logic [30:0]        m;
  logic [3:0]         bitc;
  logic [62:0]        prod;
  logic [63:0]        inc64;

  logic signed [33:0] fm_prod;
  logic [61:0]        mant_prod;
  logic signed [7:0]  sh;
  logic [63:0]        shifted;
  logic [31:0]        capped;

  always_comb begin
    fm_prod   = fm * $signed({1'b0, fm_depth});
    mant_prod = {31'b0, m} * {31'b0, exp2_bit(bitc)} + 62'(Q30_ONE >> 1);
    sh        = 8'sd30 - $signed({e[18], e[18:12]});
    if (sh >= 8'sd64) begin
      shifted = '0;
    end else if (sh >= 8'sd0) begin
      shifted = {1'b0, prod} >> sh[5:0];
    end else begin
      shifted = (prod != '0) ? '1 : '0;
    end
    capped = (inc64 > {32'b0, limits[63:32]}) ? limits[63:32] : inc64[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_FM;
          end
        end
        S_FM: begin
          e     <= {{3{pitch[15]}}, pitch} + {fm_prod[33], fm_prod[33:16]};
          m     <= Q30_ONE[30:0];
          bitc  <= '0;
          state <= S_MANT;
        end
        S_MANT: begin
          if (e[bitc]) begin
            m <= mant_prod[60:30];
          end
          if (bitc == 4'd11) begin
            state <= S_PROD;
          end
          bitc <= bitc + 4'd1;
        end
        S_PROD: begin
          prod  <= base_inc * m;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          inc64 <= shifted;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          inc   <= (capped < limits[31:0]) ? limits[31:0] : capped;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/aho_lane.sv
// One harmonic lane: gain, sine polynomial and weighted sum over its harmonic slots.
`default_nettype none
module aho_lane #(
  parameter int SINE_ADDR_BITS = 10,
  parameter int SLOTS          = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] phase,
  input  wire logic [15:0] level   [SLOTS],
  input  wire logic [15:0] cv      [SLOTS],
  input  wire logic        conn    [SLOTS],
  input  wire logic        hvalid  [SLOTS],
  input  wire logic [4:0]  hnum    [SLOTS],
  output aho_pkg::aho_lane_res_t res,
  output logic             done
);
  import aho_pkg::*;

  localparam int JW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QB = SINE_ADDR_BITS - 2;

  localparam logic [2:0] P_GAIN = 3'd0;
  localparam logic [2:0] P_SQR  = 3'd1;
  localparam logic [2:0] P_H7   = 3'd2;
  localparam logic [2:0] P_H5   = 3'd3;
  localparam logic [2:0] P_H3   = 3'd4;
  localparam logic [2:0] P_H1   = 3'd5;
  localparam logic [2:0] P_SIN  = 3'd6;
  localparam logic [2:0] P_ACC  = 3'd7;

  logic          busy;
  logic [2:0]    step;
  logic [JW-1:0] j;
  logic [30:0]   x;
  logic [30:0]   x2;
  logic [31:0]   p;
  logic [1:0]    quad;
  logic [30:0]   lc;
  logic [15:0]   amp;
  logic [14:0]   smag;

  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           mprod;
  logic [31:0]           hp;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [30:0]           xpos;
  logic [15:0]           c;
  logic [31:0]           p_new;
  logic [31:0]           sub_c;
  logic [16:0]           s_round;
  logic signed [ACC_W-1:0] term;

  always_comb begin
    hp      = 32'({27'b0, hnum[j]} * phase);
    addr    = hp[31 -: SINE_ADDR_BITS];
    xpos    = 31'(addr[QB-1:0]) << (30 - QB);
    c       = cv[j][15] ? 16'd0 : cv[j];
    mul_a   = '0;
    mul_b   = '0;
    sub_c   = SIN_A1;
    case (step)
      P_GAIN: begin
        mul_a = {16'b0, level[j]};
        mul_b = {16'b0, c};
      end
      P_SQR: begin
        mul_a = {1'b0, x};
        mul_b = {1'b0, x};
      end
      P_H7: begin
        mul_a = {1'b0, x2};
        mul_b = SIN_A9;
        sub_c = SIN_A7;
      end
      P_H5: begin
        mul_a = {1'b0, x2};
        mul_b = p;
        sub_c = SIN_A5;
      end
      P_H3: begin
        mul_a = {1'b0, x2};
        mul_b = p;
        sub_c = SIN_A3;
      end
      P_H1: begin
        mul_a = {1'b0, x2};
        mul_b = p;
        sub_c = SIN_A1;
      end
      P_SIN: begin
        mul_a = {1'b0, x};
        mul_b = p;
      end
      default: begin
        mul_a = {16'b0, amp};
        mul_b = {17'b0, smag};
      end
    endcase
    mprod   = mul_a * mul_b;
    p_new   = sub_c - mprod[61:30];
    s_round = 17'((mprod[61:30] + 32'd16384) >> 15);
    term    = quad[1] ? -$signed(ACC_W'(mprod[30:0])) : $signed(ACC_W'(mprod[30:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= P_GAIN;
      j    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step      <= P_GAIN;
        j         <= '0;
        res.acc   <= '0;
        res.total <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        case (step)
          P_GAIN: begin
            lc   <= mprod[30:0];
            quad <= addr[SINE_ADDR_BITS-1 -: 2];
            x    <= addr[QB] ? (Q30_ONE[30:0] - xpos) : xpos;
          end
          P_SQR: begin
            if (!hvalid[j]) begin
              amp <= '0;
            end else if (conn[j]) begin
              amp <= div_by_32767({1'b0, lc} + 32'd16383);
            end else begin
              amp <= level[j];
            end
            x2 <= mprod[60:30];
          end
          P_H7, P_H5, P_H3, P_H1: begin
            p <= p_new;
          end
          P_SIN: begin
            smag <= (s_round > 17'd32767) ? 15'd32767 : s_round[14:0];
          end
          default: begin
            res.acc   <= res.acc + term;
            res.total <= res.total + TOT_W'(amp);
            if (j == JW'(SLOTS - 1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
            j <= j + JW'(1);
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/aho_divider.sv
// Merge stage: sums the lane results and normalizes by the total level with a bit-serial divider.
`default_nettype none
module aho_divider (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire aho_pkg::aho_lane_res_t lane_res [aho_pkg::LANE_COUNT],
  output logic signed [15:0]          sample,
  output logic                        done
);
  import aho_pkg::*;

  localparam int QBITS = 17;
  localparam int REM_W = TOT_W + QBITS;

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_SETUP = 2'd1;
  localparam logic [1:0] D_ITER  = 2'd2;
  localparam logic [1:0] D_FIN   = 2'd3;

  logic [1:0]              state;
  logic signed [ACC_W-1:0] acc_s;
  logic [TOT_W-1:0]        tot_s;
  logic [REM_W-1:0]        rem;
  logic [QBITS-1:0]        q;
  logic [4:0]              cnt;
  logic                    neg;

  logic signed [ACC_W-1:0] acc_sum;
  logic [TOT_W-1:0]        tot_sum;
  logic [ACC_W-1:0]        mag;
  logic [REM_W-1:0]        dshift;
  logic                    qbit;
  logic [15:0]             qcap;

  always_comb begin
    acc_sum = '0;
    tot_sum = '0;
    for (int l = 0; l < LANE_COUNT; l++) begin
      acc_sum = acc_sum + lane_res[l].acc;
      tot_sum = tot_sum + lane_res[l].total;
    end
    mag    = acc_s[ACC_W-1] ? ACC_W'(-acc_s) : ACC_W'(acc_s);
    dshift = REM_W'(tot_s) << cnt;
    qbit   = (rem >= dshift);
    qcap   = (q > QBITS'(32767)) ? 16'd32767 : q[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            acc_s <= acc_sum;
            tot_s <= tot_sum;
            state <= D_SETUP;
          end
        end
        D_SETUP: begin
          if (tot_s == '0) begin
            sample <= '0;
            done   <= 1'b1;
            state  <= D_IDLE;
          end else begin
            rem   <= REM_W'(mag) + REM_W'(tot_s >> 1);
            neg   <= acc_s[ACC_W-1];
            q     <= '0;
            cnt   <= 5'(QBITS - 1);
            state <= D_ITER;
          end
        end
        D_ITER: begin
          if (qbit) begin
            rem <= rem - dshift;
          end
          q <= {q[QBITS-2:0], qbit};
          if (cnt == 5'd0) begin
            state <= D_FIN;
          end
          cnt <= cnt - 5'd1;
        end
        default: begin
          sample <= neg ? -$signed(qcap) : $signed(qcap);
          done   <= 1'b1;
          state  <= D_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire
